[rtl/dotu_pkg.sv]
package dotu_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LINE_W     = 16;
  localparam int unsigned WIN_DEPTH  = 4;

  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_FILL = 8'h78;

  // Loaded on the dot's own item and counted down there too, so the drop
  // lands when the dot reaches the oldest window slot three items later.
  localparam logic [2:0] DROP_LOAD = 3'd4;
  localparam logic [2:0] DROP_HIT  = 3'd1;

  localparam logic [1:0] PRIME_DONE = 2'd3;

  typedef struct packed {
    logic              emit;
    logic [BYTE_W-1:0] out_byte;
    logic              is_last;
    logic [LINE_W-1:0] line_count;
  } result_t;

endpackage

[rtl/dotu_core.sv]
module dotu_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [dotu_pkg::BYTE_W-1:0] byte_i,
  output dotu_pkg::result_t          res_o
);

  logic [dotu_pkg::BYTE_W-1:0] win_q [dotu_pkg::WIN_DEPTH];
  logic [dotu_pkg::BYTE_W-1:0] win_d [dotu_pkg::WIN_DEPTH];
  logic [2:0]                  drop_q, drop_d, drop_ld;
  logic [1:0]                  prime_q, prime_d;
  logic [dotu_pkg::COUNT_BITS-1:0] lines_q, lines_d;
  logic                        term, stuffed, emit;

  always_comb begin
    term    = 1'b0;
    emit    = 1'b0;
    lines_d = lines_q;
    prime_d = prime_q;

    if (byte_i == dotu_pkg::CH_LF) begin
      if (win_q[0] == dotu_pkg::CH_CR && win_q[1] == dotu_pkg::CH_LF &&
          win_q[2] == dotu_pkg::CH_DOT && win_q[3] == dotu_pkg::CH_CR) begin
        term = 1'b1;
      end else if (!(&lines_q)) begin
        lines_d = lines_q + 1'b1;
      end
    end

    stuffed = (byte_i == dotu_pkg::CH_DOT) && (win_q[2] == dotu_pkg::CH_CR) &&
              (win_q[3] == dotu_pkg::CH_LF);
    drop_ld = stuffed ? dotu_pkg::DROP_LOAD : drop_q;

    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = win_q[3];
    win_d[3] = byte_i;

    // the slot holding the stuffing dot is swallowed
    if (drop_ld == dotu_pkg::DROP_HIT) begin
      drop_d = 3'd0;
    end else begin
      drop_d = (drop_ld > dotu_pkg::DROP_HIT) ? drop_ld - 3'd1 : drop_ld;
      if (prime_q == dotu_pkg::PRIME_DONE) begin
        emit = 1'b1;
      end else begin
        prime_d = prime_q + 2'd1;
      end
    end

    res_o.emit       = emit | term;
    res_o.out_byte   = win_d[0];
    res_o.is_last    = term;
    res_o.line_count = term ? dotu_pkg::LINE_W'(lines_q) : '0;

    // terminator rearms everything for the next response
    if (term) begin
      for (int i = 0; i < dotu_pkg::WIN_DEPTH; i++) begin
        win_d[i] = dotu_pkg::CH_FILL;
      end
      drop_d  = 3'd0;
      prime_d = 2'd0;
      lines_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dotu_pkg::WIN_DEPTH; i++) begin
        win_q[i] <= dotu_pkg::CH_FILL;
      end
      drop_q  <= 3'd0;
      prime_q <= 2'd0;
      lines_q <= '0;
    end else if (step_i) begin
      win_q   <= win_d;
      drop_q  <= drop_d;
      prime_q <= prime_d;
      lines_q <= lines_d;
    end
  end

endmodule

[rtl/multiline_dot_unstuffer_unit.sv]
// Channel | Direction | Signals                          | Content
// --------+-----------+----------------------------------+------------------------------
// s_axis  | in        | tvalid, tready, tdata[7:0]       | in_byte
// m_axis  | out       | tvalid, tready, tdata[23:0],tlast | [7:0] out_byte, [23:8] line_count;
//         |           |                                  | tlast = is_last
//
// One item per cycle sustained while m_axis keeps up. An accepted item waits in the
// input register, is processed against the window state and lands in the result
// register, which drives m_axis.
// Reset (rst_ni low, async) empties both registers and loads the window with
// fill bytes. A stalled m_axis holds the result register; the input register
// keeps taking items as long as the result slot frees up in the same cycle.
module multiline_dot_unstuffer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] out_byte, [23:8] line_count
  output logic        m_axis_tlast_o    // is_last
);

  logic                        in_valid_q;
  logic [dotu_pkg::BYTE_W-1:0] in_byte_q;
  logic                        out_valid_q;
  dotu_pkg::result_t           out_q;
  dotu_pkg::result_t           res;
  logic                        out_free, advance;

  // the result slot is free if empty or drained this cycle
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || advance;

  dotu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.emit;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.line_count, out_q.out_byte};
  assign m_axis_tlast_o  = out_q.is_last;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for multiline_dot_unstuffer_unit.
// A byte queue feeds a bursty stream driver. Every accepted byte runs through
// the dot-unstuffing predictor below, which queues any expected result. The
// monitor checks each result against the oldest one in that queue.
module testbench;
  import dotu_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  multiline_dot_unstuffer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [7:0] in_byte
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] out_byte, [23:8] line_count
    .m_axis_tlast_o  (m_axis_tlast_o)    // is_last
  );

  // Bytes waiting to be sent, and results the unstuffer still owes us.
  logic [7:0] tx_bytes_q[$];
  result_t    owed_results_q[$];

  // Predictor state: history of the last four bytes, oldest in slot 0.
  logic [BYTE_W-1:0]     hist [WIN_DEPTH];
  logic [2:0]            dot_kill;
  logic [1:0]            lead_cnt;
  logic [COUNT_BITS-1:0] lf_total;

  int unsigned err_cnt;
  int unsigned bytes_in;
  int unsigned bytes_out;
  int unsigned responses_done;
  int unsigned dots_dropped;
  logic [LINE_W-1:0] top_line_count;

  task automatic rearm_predictor();
    for (int i = 0; i < WIN_DEPTH; i++) hist[i] = CH_FILL;
    dot_kill = '0;
    lead_cnt = '0;
    lf_total = '0;
  endtask

  // Advance the predictor by one received byte; queue a result if one is due.
  task automatic unstuff_byte(input logic [BYTE_W-1:0] b);
    logic    term;
    logic    emit;
    result_t r;
    term = 1'b0;
    emit = 1'b0;
    if (b == CH_LF) begin
      if (hist[0] == CH_CR && hist[1] == CH_LF && hist[2] == CH_DOT && hist[3] == CH_CR)
        term = 1'b1;
      else if (lf_total != '1)
        lf_total = lf_total + 1'b1;
    end
    // Dot right after CR LF is stuffing: it must vanish when it reaches slot 0.
    if (b == CH_DOT && hist[2] == CH_CR && hist[3] == CH_LF)
      dot_kill = DROP_LOAD;
    hist[0] = hist[1];
    hist[1] = hist[2];
    hist[2] = hist[3];
    hist[3] = b;
    if (dot_kill == DROP_HIT) begin
      dot_kill = '0;
      dots_dropped++;
    end else begin
      if (dot_kill > DROP_HIT) dot_kill = dot_kill - 1'b1;
      if (lead_cnt >= PRIME_DONE) emit = 1'b1;
      else lead_cnt = lead_cnt + 1'b1;
    end
    r.emit     = 1'b1;
    r.out_byte = hist[0];
    if (term) begin
      r.is_last    = 1'b1;
      r.line_count = LINE_W'(lf_total);
      owed_results_q.push_back(r);
      rearm_predictor();
    end else if (emit) begin
      r.is_last    = 1'b0;
      r.line_count = '0;
      owed_results_q.push_back(r);
    end
  endtask

  task automatic push_line_end();
    tx_bytes_q.push_back(CH_CR);
    tx_bytes_q.push_back(CH_LF);
  endtask

  task automatic push_terminator();
    push_line_end();
    tx_bytes_q.push_back(CH_DOT);
    push_line_end();
  endtask

  // Random text byte; mostly keeps clear of CR and LF so lines stay intact.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if ((b == CH_CR || b == CH_LF) && $urandom_range(0, 9) != 0)
      b = 8'($urandom_range(8'h20, 8'h7E));
    return b;
  endfunction

  // One well-formed response: status line, body lines with dot stuffing,
  // then the CR LF dot CR LF terminator.
  task automatic push_response();
    int unsigned n_lines;
    int unsigned n_chars;
    n_lines = $urandom_range(0, 6);
    n_chars = $urandom_range(1, 8);
    for (int i = 0; i < n_chars; i++) tx_bytes_q.push_back(text_byte());
    push_line_end();
    for (int l = 0; l < n_lines; l++) begin
      n_chars = $urandom_range(0, 12);
      // Lines that start with a dot go out doubled.
      if ($urandom_range(0, 3) == 0) begin
        tx_bytes_q.push_back(CH_DOT);
        tx_bytes_q.push_back(CH_DOT);
      end
      for (int i = 0; i < n_chars; i++) tx_bytes_q.push_back(text_byte());
      push_line_end();
    end
    tx_bytes_q.push_back(CH_DOT);
    push_line_end();
  endtask

  // Noise and broken framing: raw bytes biased toward CR, LF and dot.
  task automatic push_noise();
    int unsigned n;
    int unsigned pick;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: tx_bytes_q.push_back(CH_CR);
        1: tx_bytes_q.push_back(CH_LF);
        2: tx_bytes_q.push_back(CH_DOT);
        default: tx_bytes_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Stream driver: bursts of random length, random gaps between them.
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_axis_tvalid_i;
    nxt_data  = s_axis_tdata_i;
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (s_axis_tvalid_i) begin
        unsute_accept: begin
          unstuff_byte(s_axis_tdata_i);
          bytes_in++;
        end
      end
      nxt_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (tx_bytes_q.size() != 0) begin
        nxt_valid = 1'b1;
        nxt_data  = tx_bytes_q.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // Now and then a long burst with no gap at all.
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: switches at random between always ready, coin flip
  // and mostly stalled.
  // ---------------------------------------------------------------------------
  int unsigned rx_mode;
  int unsigned rx_mode_left;

  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(64, 256);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= 1'($urandom_range(0, 1));
      default: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor, scoreboard and stall watchdog.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles;

  always @(posedge clk_i) begin
    result_t    want;
    logic [7:0] got_byte;
    logic [15:0] got_count;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_byte  = m_axis_tdata_o[7:0];
        got_count = m_axis_tdata_o[23:8];
        bytes_out++;
        if (m_axis_tlast_o) begin
          responses_done++;
          if (got_count > top_line_count) top_line_count = got_count;
        end
        if (owed_results_q.size() == 0) begin
          $error("unexpected result: out_byte %02h is_last %0b line_count %0d",
                 got_byte, m_axis_tlast_o, got_count);
          err_cnt++;
        end else begin
          want = owed_results_q.pop_front();
          if (got_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got_byte);
            err_cnt++;
          end
          if (m_axis_tlast_o !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, m_axis_tlast_o);
            err_cnt++;
          end
          if (got_count !== want.line_count) begin
            $error("line_count: expected %0d, got %0d", want.line_count, got_count);
            err_cnt++;
          end
        end
      end
      if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: timeout, no handshake for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    burst_left      = 1;
    gap_left        = 0;
    rx_mode         = 0;
    rx_mode_left    = 0;
    idle_cycles     = 0;
    err_cnt         = 0;
    bytes_in        = 0;
    bytes_out       = 0;
    responses_done  = 0;
    dots_dropped    = 0;
    top_line_count  = '0;
    rearm_predictor();

    // Directed: a dot at response start is payload, a doubled dot loses one,
    // byte extremes, a terminator, then a minimal second response.
    tx_bytes_q.push_back(CH_DOT);
    tx_bytes_q.push_back(8'h78);
    push_line_end();
    tx_bytes_q.push_back(CH_DOT);
    tx_bytes_q.push_back(CH_DOT);
    tx_bytes_q.push_back(8'h79);
    push_line_end();
    tx_bytes_q.push_back(8'h00);
    tx_bytes_q.push_back(8'hFF);
    push_terminator();
    tx_bytes_q.push_back(8'h5A);
    push_terminator();

    // Random mix: mostly well-formed responses, some noise in between.
    while (tx_bytes_q.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) push_noise();
      else push_response();
    end
    // Always leave the stream on a clean response boundary.
    push_response();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (tx_bytes_q.size() != 0 || s_axis_tvalid_i || owed_results_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d bytes in, %0d bytes out, %0d responses closed",
             bytes_in, bytes_out, responses_done);
    $display("tb: %0d stuffing dots removed, highest line count %0d",
             dots_dropped, top_line_count);
    if (err_cnt == 0 && owed_results_q.size() == 0) begin
      $display("tb: success");
    end else begin
      if (owed_results_q.size() != 0)
        $error("%0d expected results never arrived", owed_results_q.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dotu_pkg.sv
rtl/dotu_core.sv
rtl/multiline_dot_unstuffer_unit.sv
verif/testbench.sv
